[rtl/led_nibble_frame_shift_driver_top_defines.svh]
// Assertion macros used by the port checker file.
`ifndef LED_NIBBLE_FRAME_SHIFT_DRIVER_TOP_DEFINES_SVH
`define LED_NIBBLE_FRAME_SHIFT_DRIVER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define LNFSD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define LNFSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/lnfsd_pkg.sv]
// Types, constants and color mapping for the LED nibble frame shift driver.
`default_nettype none
package lnfsd_pkg;

    localparam int IDX_W  = 5;
    localparam int CODE_W = 3;
    localparam int NIB_W  = 4;
    localparam int BYTE_W = 8;

    typedef enum logic {
        KIND_SET     = 1'b0,
        KIND_REFRESH = 1'b1
    } lnfsd_kind_t;

    typedef enum logic [CODE_W-1:0] {
        CODE_OFF   = 3'd0,
        CODE_RED   = 3'd1,
        CODE_WHITE = 3'd2,
        CODE_BLUE  = 3'd3,
        CODE_GREEN = 3'd4
    } lnfsd_code_t;

    localparam logic [NIB_W-1:0] COLOR_RED   = 4'h8;
    localparam logic [NIB_W-1:0] COLOR_WHITE = 4'h1;
    localparam logic [NIB_W-1:0] COLOR_BLUE  = 4'h2;
    localparam logic [NIB_W-1:0] COLOR_GREEN = 4'h4;
    localparam logic [NIB_W-1:0] COLOR_OFF   = 4'h0;

    typedef enum logic {
        SHIFT_IDLE = 1'b0,
        SHIFT_RUN  = 1'b1
    } lnfsd_state_t;

    typedef struct packed {
        logic              set_en;
        logic              load_en;
        logic [IDX_W-1:0]  led_index;
        logic [CODE_W-1:0] color_code;
    } lnfsd_req_t;

    function automatic logic [NIB_W-1:0] color_bits(input logic [CODE_W-1:0] code);
        logic [NIB_W-1:0] bits;
        case (code)
            CODE_RED:   bits = COLOR_RED;
            CODE_WHITE: bits = COLOR_WHITE;
            CODE_BLUE:  bits = COLOR_BLUE;
            CODE_GREEN: bits = COLOR_GREEN;
            default:    bits = COLOR_OFF;
        endcase
        return bits;
    endfunction

endpackage
`default_nettype wire

[rtl/lnfsd_frame.sv]
// Pending and shown frame store with set decode and change detect.
`default_nettype none
module lnfsd_frame #(
    parameter int LED_COUNT   = 16,
    parameter int FRAME_BYTES = 8
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  lnfsd_pkg::lnfsd_req_t          req,
    output logic [FRAME_BYTES*8-1:0]       frame,
    output logic                           differ
);
    import lnfsd_pkg::*;

    localparam int SLOTS   = 2 * FRAME_BYTES;
    localparam int SLOT_IW = $clog2(SLOTS);
    localparam logic [IDX_W-1:0] LAST_LED  = IDX_W'(LED_COUNT - 1);
    localparam logic [IDX_W-1:0] LED_LIM   = IDX_W'(LED_COUNT);
    localparam logic [IDX_W-1:0] SLOT_LIM  = IDX_W'(SLOTS);

    logic [SLOTS-1:0][NIB_W-1:0] pend_reg, pend_next;
    logic [SLOTS-1:0][NIB_W-1:0] shown_reg, shown_next;
    logic [IDX_W-1:0]            slot;
    logic                        in_range;

    assign slot     = LAST_LED - req.led_index;
    assign in_range = (req.led_index < LED_LIM) && (slot < SLOT_LIM);
    assign differ   = (pend_reg != shown_reg);
    assign frame    = pend_reg;

    always_comb begin
        pend_next = pend_reg;
        if (req.set_en && in_range) begin
            pend_next[slot[SLOT_IW-1:0]] = color_bits(req.color_code);
        end
    end

    always_comb begin
        shown_next = shown_reg;
        if (req.load_en && differ) begin
            shown_next = pend_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg  <= '0;
            shown_reg <= '0;
        end else begin
            pend_reg  <= pend_next;
            shown_reg <= shown_next;
        end
    end

endmodule
`default_nettype wire

[rtl/lnfsd_shifter.sv]
// Serializer: shifts the frame out one bit per accepted output transfer, LSB first.
`default_nettype none
module lnfsd_shifter #(
    parameter int FRAME_BYTES = 8
) (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       load,
    input  wire [FRAME_BYTES*8-1:0]   frame_in,
    output logic                      idle,
    output logic                      m_tvalid,
    input  wire                       m_tready,
    output logic [7:0]                m_tdata,   // [0] serial_bit, [7:1] zero
    output logic                      m_tlast    // latch_after
);
    import lnfsd_pkg::*;

    localparam int FW    = FRAME_BYTES * 8;
    localparam int CNT_W = $clog2(FW);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FW - 1);

    lnfsd_state_t     state_reg, state_next;
    logic [FW-1:0]    sh_reg, sh_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_accept;
    logic             at_last;

    assign out_accept = m_tvalid && m_tready;
    assign at_last    = (cnt_reg == CNT_LAST);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            SHIFT_IDLE: begin
                if (load) begin
                    state_next = SHIFT_RUN;
                end
            end
            SHIFT_RUN: begin
                if (out_accept && at_last) begin
                    state_next = SHIFT_IDLE;
                end
            end
            default: state_next = SHIFT_IDLE;
        endcase
    end

    always_comb begin
        idle     = 1'b0;
        m_tvalid = 1'b0;
        case (state_reg)
            SHIFT_IDLE: idle     = 1'b1;
            SHIFT_RUN:  m_tvalid = 1'b1;
            default:    idle     = 1'b0;
        endcase
    end

    assign m_tdata = {7'b0, sh_reg[0]};
    assign m_tlast = at_last;

    always_comb begin
        sh_next  = sh_reg;
        cnt_next = cnt_reg;
        if (load) begin
            sh_next  = frame_in;
            cnt_next = '0;
        end else if (out_accept) begin
            sh_next  = sh_reg >> 1;
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SHIFT_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        sh_reg <= sh_next;
    end

endmodule
`default_nettype wire

[rtl/led_nibble_frame_shift_driver_top.sv]
// Top level of the LED nibble frame shift driver.
// A set request writes one LED nibble. A refresh request that finds the pending
// frame equal to the shown frame emits nothing; otherwise it copies the frame and
// the serializer sends FRAME_BYTES*8 bits, one per accepted output cycle (64 at
// defaults), byte 0 first and LSB first, with tlast on the final bit where the
// latch is pulsed. The input side is not ready while the serializer is busy.
`default_nettype none
module led_nibble_frame_shift_driver_top #(
    parameter int LED_COUNT   = 16,
    parameter int FRAME_BYTES = 8
) (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire [7:0]  s_tdata,   // [4:0] led_index, [7:5] color_code
    input  wire        s_tuser,   // kind
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [7:0] m_tdata,   // [0] serial_bit, [7:1] zero
    output logic       m_tlast    // latch_after
);
    import lnfsd_pkg::*;

    localparam int FW = FRAME_BYTES * 8;

    lnfsd_req_t  req;
    logic [FW-1:0] frame;
    logic        differ;
    logic        in_accept;
    logic        idle;

    assign in_accept      = s_tvalid && s_tready;
    assign s_tready       = idle;
    assign req.set_en     = in_accept && (s_tuser == KIND_SET);
    assign req.load_en    = in_accept && (s_tuser == KIND_REFRESH);
    assign req.led_index  = s_tdata[IDX_W-1:0];
    assign req.color_code = s_tdata[IDX_W+CODE_W-1:IDX_W];

    lnfsd_frame #(
        .LED_COUNT   (LED_COUNT),
        .FRAME_BYTES (FRAME_BYTES)
    ) u_frame (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .frame   (frame),
        .differ  (differ)
    );

    lnfsd_shifter #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_shifter (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (req.load_en && differ),
        .frame_in (frame),
        .idle     (idle),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire

[rtl/lnfsd_checker.sv]
// Port-level checker for the LED nibble frame shift driver, with its bind.
`default_nettype none
`include "led_nibble_frame_shift_driver_top_defines.svh"
module lnfsd_port_checker (
    input wire       aclk,
    input wire       aresetn,
    input wire       s_tvalid,
    input wire       s_tready,
    input wire       s_tuser,
    input wire       m_tvalid,
    input wire       m_tready,
    input wire [7:0] m_tdata,
    input wire       m_tlast
);
    import lnfsd_pkg::*;

    `LNFSD_ASSERT_NOW(a_busy_blocks_input, m_tvalid, !s_tready, "input ready while shifting")
    `LNFSD_ASSERT_NEXT(a_stall_holds, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled output changed")
    `LNFSD_ASSERT_NEXT(a_last_ends_run, m_tvalid && m_tready && m_tlast, !m_tvalid,
        "output continues after last bit")
    `LNFSD_ASSERT_NEXT(a_set_is_silent, s_tvalid && s_tready && (s_tuser == KIND_SET),
        !m_tvalid, "set request produced output")

endmodule

bind led_nibble_frame_shift_driver_top lnfsd_port_checker u_lnfsd_checker (.*);
`default_nettype wire
